// ===== hdl/aabb_frustum_cull_assert.svh =====
// Assertion shorthands shared by the RTL.
`ifndef AABB_FRUSTUM_CULL_ASSERT_SVH
`define AABB_FRUSTUM_CULL_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define AFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aabb_frustum_cull: assertion failed");

// Check that cons holds in the cycle after ante.
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aabb_frustum_cull: assertion failed");

`endif

// ===== hdl/afc_pkg.sv =====
`timescale 1ns / 1ps

package afc_pkg;

	localparam int PLANE_REGS      = 6;
	localparam int PLANE_W         = 64;
	localparam int NORM_W          = 16;
	localparam int NORM_FRAC       = 14;
	localparam int DIST_W          = 16;
	localparam int DIST_LSB        = 48;
	localparam int CFG_IDX_W       = $clog2(PLANE_REGS);
	localparam int NUM_PLANES_DEF  = 6;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int AXES            = 3;

	typedef struct packed {
		logic valid;
		logic vis;
	} afc_ctl_t;

endpackage

// ===== hdl/afc_if.sv =====
`timescale 1ns / 1ps

interface afc_box_if #(
	parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic signed [COORD_WIDTH-1:0] center_z;
	logic        [COORD_WIDTH-2:0] half_x;
	logic        [COORD_WIDTH-2:0] half_y;
	logic        [COORD_WIDTH-2:0] half_z;

	modport source (
		output valid, center_x, center_y, center_z, half_x, half_y, half_z,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, center_z, half_x, half_y, half_z,
		output ready
	);
endinterface

interface afc_vis_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

// ===== hdl/aabb_frustum_cull.sv =====
`timescale 1ns / 1ps
// channel   dir  beat contents
// box       in   center_x/y/z (signed Q8.8), half_x/y/z (Q7.8)
// result    out  visible
// cfg_*     in   plane write: cfg_index selects plane, cfg_data packed plane
//
// One box per cycle unless a result waits untaken; two stages per plane cell
// (products, then sum and compare against the plane distance).
// Reset zeroes all planes, so no plane rejects until written.
// A result not taken freezes the whole chain and drops box.ready.

`include "aabb_frustum_cull_assert.svh"

module aabb_frustum_cull #(
	parameter int NUM_PLANES  = afc_pkg::NUM_PLANES_DEF,
	parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	afc_box_if.sink                       box,
	afc_vis_if.source                     result,
	input  logic                          cfg_we,
	input  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afc_pkg::PLANE_W-1:0]   cfg_data
);

	afc_pkg::afc_ctl_t             ctl    [NUM_PLANES+1];
	logic signed [COORD_WIDTH-1:0] center [NUM_PLANES+1][afc_pkg::AXES];
	logic        [COORD_WIDTH-2:0] half   [NUM_PLANES+1][afc_pkg::AXES];
	logic [NUM_PLANES-1:0]         chain_valid;
	logic                          advance;

	assign advance   = !ctl[NUM_PLANES].valid || result.ready;
	assign box.ready = advance;

	assign ctl[0].valid = box.valid;
	assign ctl[0].vis   = 1'b1;
	assign center[0][0] = box.center_x;
	assign center[0][1] = box.center_y;
	assign center[0][2] = box.center_z;
	assign half[0][0]   = box.half_x;
	assign half[0][1]   = box.half_y;
	assign half[0][2]   = box.half_z;

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
		afc_cell #(
			.COORD_WIDTH (COORD_WIDTH),
			.IDX         (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (advance),
			.cfg_we     (cfg_we),
			.cfg_index  (cfg_index),
			.cfg_data   (cfg_data),
			.ctl_in     (ctl[i]),
			.center_in  (center[i]),
			.half_in    (half[i]),
			.ctl_out    (ctl[i+1]),
			.center_out (center[i+1]),
			.half_out   (half[i+1])
		);
		assign chain_valid[i] = ctl[i+1].valid;
	end

	assign result.valid   = ctl[NUM_PLANES].valid;
	assign result.visible = ctl[NUM_PLANES].vis;

	`AFC_ASSERT_SAME(a_stall_blocks_input, clk, arst_n,
		result.valid && !result.ready, !box.ready)
	`AFC_ASSERT_NEXT(a_beat_reaches_cell, clk, arst_n,
		(box.valid && box.ready ##1 advance), ctl[1].valid)
	`AFC_ASSERT_NEXT(a_stall_freezes_chain, clk, arst_n,
		!advance, $stable(chain_valid))

endmodule

// ===== hdl/afc_cell.sv =====
`timescale 1ns / 1ps

module afc_cell #(
	parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF,
	parameter int IDX         = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               cfg_we,
	input  logic [afc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [afc_pkg::PLANE_W-1:0]        cfg_data,
	input  afc_pkg::afc_ctl_t                  ctl_in,
	input  logic signed [COORD_WIDTH-1:0]      center_in [afc_pkg::AXES],
	input  logic        [COORD_WIDTH-2:0]      half_in   [afc_pkg::AXES],
	output afc_pkg::afc_ctl_t                  ctl_out,
	output logic signed [COORD_WIDTH-1:0]      center_out [afc_pkg::AXES],
	output logic        [COORD_WIDTH-2:0]      half_out   [afc_pkg::AXES]
);

	localparam int  P_W      = COORD_WIDTH + 1;
	localparam int  PROD_W   = afc_pkg::NORM_W + P_W;
	localparam int  DSC_W    = afc_pkg::DIST_W + afc_pkg::NORM_FRAC;
	localparam int  SUM_W    = PROD_W + 2;
	localparam int  ACC_W    = ((SUM_W > DSC_W) ? SUM_W : DSC_W) + 1;
	localparam bit  WRITABLE = (IDX < afc_pkg::PLANE_REGS);

	logic [afc_pkg::PLANE_W-1:0]          plane_q;
	afc_pkg::afc_ctl_t                    ctl_s1;
	afc_pkg::afc_ctl_t                    ctl_s2;
	logic signed [PROD_W-1:0]             prod_s1   [afc_pkg::AXES];
	logic signed [COORD_WIDTH-1:0]        center_s1 [afc_pkg::AXES];
	logic        [COORD_WIDTH-2:0]        half_s1   [afc_pkg::AXES];
	logic signed [COORD_WIDTH-1:0]        center_s2 [afc_pkg::AXES];
	logic        [COORD_WIDTH-2:0]        half_s2   [afc_pkg::AXES];
	logic signed [afc_pkg::NORM_W-1:0]    norm      [afc_pkg::AXES];
	logic signed [P_W-1:0]                corner    [afc_pkg::AXES];
	logic signed [PROD_W-1:0]             prod      [afc_pkg::AXES];
	logic signed [DSC_W-1:0]              dist_sc;
	logic signed [ACC_W-1:0]              acc;
	logic                                 cfg_hit;

	assign cfg_hit = WRITABLE && cfg_we && (cfg_index == afc_pkg::CFG_IDX_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_hit) begin
			plane_q <= cfg_data;
		end
	end

	// Pick the corner farthest along the normal, per axis.
	always_comb begin
		for (int a = 0; a < afc_pkg::AXES; a++) begin
			norm[a]   = $signed(plane_q[a*afc_pkg::NORM_W +: afc_pkg::NORM_W]);
			corner[a] = norm[a][afc_pkg::NORM_W-1]
				? ($signed({center_in[a][COORD_WIDTH-1], center_in[a]}) -
				   $signed({2'b00, half_in[a]}))
				: ($signed({center_in[a][COORD_WIDTH-1], center_in[a]}) +
				   $signed({2'b00, half_in[a]}));
			prod[a]   = PROD_W'(norm[a]) * PROD_W'(corner[a]);
		end
	end

	assign dist_sc = $signed({plane_q[afc_pkg::DIST_LSB +: afc_pkg::DIST_W],
		{afc_pkg::NORM_FRAC{1'b0}}});
	assign acc = ACC_W'(prod_s1[0]) + ACC_W'(prod_s1[1]) + ACC_W'(prod_s1[2])
		- ACC_W'(dist_sc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1     <= ctl_in;
			ctl_s2.valid <= ctl_s1.valid;
			ctl_s2.vis   <= ctl_s1.vis && !acc[ACC_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1   <= prod;
			center_s1 <= center_in;
			half_s1   <= half_in;
			center_s2 <= center_s1;
			half_s2   <= half_s1;
		end
	end

	assign ctl_out    = ctl_s2;
	assign center_out = center_s2;
	assign half_out   = half_s2;

endmodule
